// ===== rtl/quadrature_mouse_report_macros.svh =====
// ----------------------------------------------------------------------------
// quadrature_mouse_report_macros.svh
// Assertion macros shared by the mouse report block.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_MOUSE_REPORT_MACROS_SVH
`define QUADRATURE_MOUSE_REPORT_MACROS_SVH

// same-cycle implication, checked only out of reset
`define QMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked only out of reset
`define QMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmr_pkg
// Types, constants and the transition table for the mouse report block.
// ----------------------------------------------------------------------------
package qmr_pkg;

    // step decoded from one phase transition: -1, 0 or +1
    typedef logic signed [1:0] step_t;

    localparam step_t STEP_UP   = 2'sd1;
    localparam step_t STEP_DOWN = -2'sd1;
    localparam step_t STEP_NONE = 2'sd0;

    // index is {previous phase, current phase}
    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    localparam int SCALE_W   = 3;
    localparam int ACCUM_W   = 8;
    localparam int BUTTON_W  = 3;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [SCALE_W-1:0] COUNT_SCALE_RESET = 3'd2;
    localparam logic [PADDR_W-1:0] ADDR_COUNT_SCALE  = 2'd0;

    // button bit positions in the report
    localparam int BTN_LEFT   = 0;
    localparam int BTN_MIDDLE = 1;
    localparam int BTN_RIGHT  = 2;

    // one registered input beat
    typedef struct packed {
        logic [1:0] h_phase;
        logic [1:0] v_phase;
        logic       left_pin;
        logic       middle_pin;
        logic       right_pin;
        logic       report_request;
    } sample_t;

    // per-axis control from the top level
    typedef struct packed {
        logic advance;  // consume the registered sample
        logic clear;    // report issued, restart the count
    } axis_ctrl_t;

endpackage

// ===== rtl/quadrature_mouse_report.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_mouse_report
// Two-axis quadrature decoder with a three-button relative mouse report.
// ----------------------------------------------------------------------------
// One pin sample is taken per clock with no bubbles unless a report sample
// stalls. A beat is captured in an input register. Once it advances, it is
// decoded and accumulated, and any report it requests is loaded into the
// output register at the same edge as the accumulators, which offers it on
// the result channel. Throughput is one sample per cycle while no report is
// stalled, set by the combinational table lookup and 8-bit add per axis;
// samples that request no report never wait on the result channel, while a
// report waits only when the output register still holds an untaken report.
// count_scale sits at byte address 0 and resets to 2.
module quadrature_mouse_report (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_h_phase_a,
    input  logic                                s_h_phase_b,
    input  logic                                s_v_phase_a,
    input  logic                                s_v_phase_b,
    input  logic                                s_left_pin,
    input  logic                                s_middle_pin,
    input  logic                                s_right_pin,
    input  logic                                s_report_request,
    // report channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qmr_pkg::ACCUM_W-1:0]  m_delta_x,
    output logic signed [qmr_pkg::ACCUM_W-1:0]  m_delta_y,
    output logic [qmr_pkg::BUTTON_W-1:0]        m_button_bits,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qmr_pkg::PADDR_W-1:0]         paddr,
    input  logic [qmr_pkg::PDATA_W-1:0]         pwdata,
    output logic [qmr_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import qmr_pkg::*;
    `include "quadrature_mouse_report_macros.svh"

    logic                       in_valid_reg;
    sample_t                    in_sample_reg;
    logic                       m_valid_reg;
    logic signed [ACCUM_W-1:0]  delta_x_reg;
    logic signed [ACCUM_W-1:0]  delta_y_reg;
    logic [BUTTON_W-1:0]        buttons_reg;
    logic [BUTTON_W-1:0]        buttons;
    logic [SCALE_W-1:0]         count_scale;
    logic signed [ACCUM_W-1:0]  delta_x;
    logic signed [ACCUM_W-1:0]  delta_y;
    logic                       advance;
    logic                       report;
    axis_ctrl_t                 axis_ctrl;

    // configuration
    qmr_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .count_scale (count_scale)
    );

    // registered sample moves on unless a report finds the output full
    assign report    = in_valid_reg && in_sample_reg.report_request;
    assign advance   = in_valid_reg &&
                       (!in_sample_reg.report_request || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign axis_ctrl = '{advance: advance, clear: report};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_sample_reg <= '{
                h_phase:        {s_h_phase_a, s_h_phase_b},
                v_phase:        {s_v_phase_a, s_v_phase_b},
                left_pin:       s_left_pin,
                middle_pin:     s_middle_pin,
                right_pin:      s_right_pin,
                report_request: s_report_request
            };
        end
    end

    // axis decoders
    qmr_axis u_axis_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (axis_ctrl),
        .phase   (in_sample_reg.h_phase),
        .scale   (count_scale),
        .delta   (delta_x)
    );

    qmr_axis u_axis_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (axis_ctrl),
        .phase   (in_sample_reg.v_phase),
        .scale   (count_scale),
        .delta   (delta_y)
    );

    // buttons are active low on the pins
    always_comb begin
        buttons             = '0;
        buttons[BTN_LEFT]   = !in_sample_reg.left_pin;
        buttons[BTN_MIDDLE] = !in_sample_reg.middle_pin;
        buttons[BTN_RIGHT]  = !in_sample_reg.right_pin;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && report) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && report) begin
            delta_x_reg <= delta_x;
            delta_y_reg <= delta_y;
            buttons_reg <= buttons;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_delta_x     = delta_x_reg;
    assign m_delta_y     = delta_y_reg;
    assign m_button_bits = buttons_reg;

    // checks
    `QMR_ASSERT_NEXT(a_report_loads_output, advance && report, m_valid_reg,
        "report beat did not reach the output register")
    `QMR_ASSERT_NEXT(a_blocked_sample_held, in_valid_reg && !advance, in_valid_reg,
        "blocked sample was dropped from the input register")
    `QMR_ASSERT_NOW(a_empty_input_ready, !in_valid_reg, s_ready,
        "input register empty but sample channel not ready")
    `QMR_ASSERT_NOW(a_stall_only_on_report, in_valid_reg && !advance,
        in_sample_reg.report_request && m_valid_reg && !m_ready,
        "sample stalled without a pending report")

endmodule

// ===== rtl/qmr_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmr_axis
// One quadrature axis: transition lookup, scaling and 8-bit wrap accumulator.
// ----------------------------------------------------------------------------
module qmr_axis (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qmr_pkg::axis_ctrl_t           ctrl,
    input  logic [1:0]                    phase,
    input  logic [qmr_pkg::SCALE_W-1:0]   scale,
    output logic signed [qmr_pkg::ACCUM_W-1:0] delta
);
    import qmr_pkg::*;

    logic [1:0]                prev_reg;
    logic signed [ACCUM_W-1:0] accum_reg;
    logic [3:0]                idx;
    step_t                     step;
    logic signed [ACCUM_W-1:0] incr;
    logic [ACCUM_W-1:0]        scale_ext;

    // transition lookup
    assign idx       = {prev_reg, phase};
    assign step      = STEP_TABLE[idx];
    assign scale_ext = {{(ACCUM_W-SCALE_W){1'b0}}, scale};

    // step times scale is just +scale, -scale or zero
    always_comb begin
        case (step)
            STEP_UP:   incr = $signed(scale_ext);
            STEP_DOWN: incr = -$signed(scale_ext);
            default:   incr = '0;
        endcase
    end

    // count including the current sample, wraps modulo 256
    assign delta = accum_reg + incr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            accum_reg <= '0;
        end else if (ctrl.advance) begin
            prev_reg  <= phase;
            accum_reg <= ctrl.clear ? '0 : delta;
        end
    end

endmodule

// ===== rtl/qmr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmr_regs
// APB register file holding the count scale.
// ----------------------------------------------------------------------------
module qmr_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qmr_pkg::PADDR_W-1:0]   paddr,
    input  logic [qmr_pkg::PDATA_W-1:0]   pwdata,
    output logic [qmr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [qmr_pkg::SCALE_W-1:0]   count_scale
);
    import qmr_pkg::*;

    logic [SCALE_W-1:0] count_scale_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_COUNT_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_scale_reg <= COUNT_SCALE_RESET;
        end else if (wr_en) begin
            count_scale_reg <= pwdata[SCALE_W-1:0];
        end
    end

    // read back
    always_comb begin
        unique case (paddr)
            ADDR_COUNT_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, count_scale_reg};
            default:          prdata = '0;
        endcase
    end

    assign count_scale = count_scale_reg;

endmodule

// ===== tb/sv/tb_quadrature_mouse_report.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_mouse_report
// Self-checking bench for the two-axis quadrature mouse report block.
// ----------------------------------------------------------------------------
// Pin samples are queued by the stimulus process and handed to the block by a
// valid/ready driver. A monitor tracks every accepted sample in a local model
// of the decoder and accumulators, and checks each report beat against the
// oldest predicted report. The run goes through directed cases, then random
// encoder walks, noise and long one-way spins under several count_scale
// settings. Both channels idle in random bursts; one long report-side stall
// backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_quadrature_mouse_report;
    import qmr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_STALL   = 80;

    // active-low button pin patterns, ordered {left, middle, right}
    localparam logic [2:0] BTN_N_NONE   = 3'b111;
    localparam logic [2:0] BTN_N_ALL    = 3'b000;
    localparam logic [2:0] BTN_N_LEFT   = 3'b011;
    localparam logic [2:0] BTN_N_MIDDLE = 3'b101;
    localparam logic [2:0] BTN_N_RIGHT  = 3'b110;

    typedef struct packed {
        logic [1:0] h_phase;    // {a, b}
        logic [1:0] v_phase;    // {a, b}
        logic [2:0] btn_n;      // {left, middle, right}, 0 = pressed
        logic       req;
    } pin_sample_t;

    typedef struct packed {
        logic signed [ACCUM_W-1:0] delta_x;
        logic signed [ACCUM_W-1:0] delta_y;
        logic [BUTTON_W-1:0]       buttons;
    } mouse_report_t;

    // clock, reset and block ports
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid          = 1'b0;
    logic s_ready;
    logic s_h_phase_a      = 1'b0;
    logic s_h_phase_b      = 1'b0;
    logic s_v_phase_a      = 1'b0;
    logic s_v_phase_b      = 1'b0;
    logic s_left_pin       = 1'b1;
    logic s_middle_pin     = 1'b1;
    logic s_right_pin      = 1'b1;
    logic s_report_request = 1'b0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [ACCUM_W-1:0]  m_delta_x;
    logic signed [ACCUM_W-1:0]  m_delta_y;
    logic [BUTTON_W-1:0]        m_button_bits;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    quadrature_mouse_report DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_h_phase_a      (s_h_phase_a),
        .s_h_phase_b      (s_h_phase_b),
        .s_v_phase_a      (s_v_phase_a),
        .s_v_phase_b      (s_v_phase_b),
        .s_left_pin       (s_left_pin),
        .s_middle_pin     (s_middle_pin),
        .s_right_pin      (s_right_pin),
        .s_report_request (s_report_request),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_delta_x        (m_delta_x),
        .m_delta_y        (m_delta_y),
        .m_button_bits    (m_button_bits),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // bench state
    pin_sample_t   sample_fifo[$];
    mouse_report_t pending_reports[$];

    bit in_fire      = 1'b0;
    bit idle_on      = 1'b1;
    int tx_idle_pct  = 10;
    int rx_idle_pct  = 10;
    int tx_gap       = 0;
    int rx_hold      = 0;
    int rx_hold_req  = 0;

    int mismatch_count  = 0;
    int samples_seen    = 0;
    int reports_checked = 0;
    int stall_cycles    = 0;
    int settings_used   = 1;
    int cycle_count     = 0;

    // generator position of each axis along the forward gray sequence
    int gen_h_pos = 0;
    int gen_v_pos = 0;

    // decoder model state
    logic [SCALE_W-1:0] scale_now = COUNT_SCALE_RESET;
    logic [1:0]         prev_h    = 2'b00;
    logic [1:0]         prev_v    = 2'b00;
    logic [ACCUM_W-1:0] x_total   = '0;
    logic [ACCUM_W-1:0] y_total   = '0;

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // forward rotation visits 00, 10, 11, 01
    function automatic int gray_pos(input logic [1:0] ph);
        case (ph)
            2'b00:   return 0;
            2'b10:   return 1;
            2'b11:   return 2;
            default: return 3;
        endcase
    endfunction

    function automatic logic [1:0] phase_at(input int pos);
        case (pos & 3)
            0:       return 2'b00;
            1:       return 2'b10;
            2:       return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    // one quarter turn either way counts; no move or a half turn counts zero
    function automatic int quad_step(input logic [1:0] from_ph, input logic [1:0] to_ph);
        int diff;
        diff = (gray_pos(to_ph) - gray_pos(from_ph)) & 3;
        if (diff == 1)
            return 1;
        if (diff == 3)
            return -1;
        return 0;
    endfunction

    // advance the model by one accepted sample, queue a report if requested
    task automatic track_sample(input pin_sample_t smp);
        mouse_report_t rpt;
        x_total = x_total + ACCUM_W'(quad_step(prev_h, smp.h_phase) * int'(scale_now));
        y_total = y_total + ACCUM_W'(quad_step(prev_v, smp.v_phase) * int'(scale_now));
        prev_h  = smp.h_phase;
        prev_v  = smp.v_phase;
        if (smp.req) begin
            rpt.delta_x             = x_total;
            rpt.delta_y             = y_total;
            rpt.buttons[BTN_LEFT]   = ~smp.btn_n[2];
            rpt.buttons[BTN_MIDDLE] = ~smp.btn_n[1];
            rpt.buttons[BTN_RIGHT]  = ~smp.btn_n[0];
            pending_reports.push_back(rpt);
            x_total = '0;
            y_total = '0;
        end
    endtask

    // queue one sample and keep the generator in step with it
    task automatic push_sample(input logic [1:0] h, input logic [1:0] v,
                               input logic [2:0] btn_n, input logic req);
        sample_fifo.push_back('{h_phase: h, v_phase: v, btn_n: btn_n, req: req});
        gen_h_pos = gray_pos(h);
        gen_v_pos = gray_pos(v);
    endtask

    function automatic int next_pos(input int pos, input int dir, input int bad_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < bad_pct)
            return (pos + 2) & 3;
        if (r < bad_pct + 70)
            return (pos + dir) & 3;
        if (r < bad_pct + 88)
            return pos;
        return (pos - dir) & 3;
    endfunction

    // encoder walk with a drift direction per axis and occasional glitches
    task automatic queue_motion(input int n, input int req_pct, input int bad_pct);
        int hdir;
        int vdir;
        hdir = $urandom_range(0, 1) ? 1 : -1;
        vdir = $urandom_range(0, 1) ? 1 : -1;
        repeat (n) begin
            push_sample(phase_at(next_pos(gen_h_pos, hdir, bad_pct)),
                        phase_at(next_pos(gen_v_pos, vdir, bad_pct)),
                        3'($urandom), $urandom_range(0, 99) < req_pct);
        end
    endtask

    task automatic queue_noise(input int n);
        repeat (n)
            push_sample(2'($urandom), 2'($urandom), 3'($urandom), 1'($urandom));
    endtask

    // steady rotation, x one way and y the other, reported at the end
    task automatic queue_spin(input int n);
        int dir;
        dir = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k < n; k++)
            push_sample(phase_at(gen_h_pos + dir), phase_at(gen_v_pos - dir),
                        3'($urandom), k == n - 1);
    endtask

    // block is idle once every sample is taken and every report is back
    task automatic wait_drained();
        while (sample_fifo.size() != 0 || s_valid || pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write count_scale, then read it back
    task automatic write_scale(input logic [SCALE_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_COUNT_SCALE;
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        scale_now = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[SCALE_W-1:0] !== value)
            report_error($sformatf("count_scale readback %0d, wrote %0d",
                                   prdata[SCALE_W-1:0], value));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // sample driver: a new beat goes out once the previous one is taken
    always @(negedge aclk) begin : sample_driver
        pin_sample_t nxt;
        if (!s_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < tx_idle_pct) begin
                tx_gap = $urandom_range(1, 14) - 1;
                s_valid <= 1'b0;
            end else if (sample_fifo.size() != 0) begin
                nxt = sample_fifo.pop_front();
                {s_h_phase_a, s_h_phase_b, s_v_phase_a, s_v_phase_b,
                 s_left_pin, s_middle_pin, s_right_pin, s_report_request} <= nxt;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // report receiver: random stall bursts plus one requested long hold-off
    always @(negedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_hold     = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_hold = $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: track accepted samples, check report beats
    always @(posedge aclk) begin : beat_monitor
        mouse_report_t want;
        in_fire = 1'b0;
        if (aresetn) begin
            in_fire = s_valid && s_ready;
            if (s_valid && !s_ready)
                stall_cycles++;
            if (in_fire) begin
                samples_seen++;
                track_sample({s_h_phase_a, s_h_phase_b, s_v_phase_a, s_v_phase_b,
                              s_left_pin, s_middle_pin, s_right_pin, s_report_request});
            end
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    report_error($sformatf("unexpected report dx=%0d dy=%0d buttons=%b",
                                           m_delta_x, m_delta_y, m_button_bits));
                end else begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    if (m_delta_x !== want.delta_x)
                        report_error($sformatf("delta_x %0d, expected %0d",
                                               m_delta_x, want.delta_x));
                    if (m_delta_y !== want.delta_y)
                        report_error($sformatf("delta_y %0d, expected %0d",
                                               m_delta_y, want.delta_y));
                    if (m_button_bits !== want.buttons)
                        report_error($sformatf("button_bits %b, expected %b",
                                               m_button_bits, want.buttons));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports still expected",
                     cycle_count, pending_reports.size());
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        logic [SCALE_W-1:0] scale_plan [7];
        scale_plan = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd5, 3'd3, 3'd4};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed cases at the reset scale
        push_sample(2'b00, 2'b00, BTN_N_ALL,    1'b1);  // empty report, all pressed
        push_sample(2'b10, 2'b00, BTN_N_NONE,   1'b0);  // full forward turn on x
        push_sample(2'b11, 2'b00, BTN_N_NONE,   1'b0);
        push_sample(2'b01, 2'b00, BTN_N_NONE,   1'b0);
        push_sample(2'b00, 2'b00, BTN_N_NONE,   1'b1);
        push_sample(2'b00, 2'b01, BTN_N_LEFT,   1'b0);  // full backward turn on y
        push_sample(2'b00, 2'b11, BTN_N_LEFT,   1'b0);
        push_sample(2'b00, 2'b10, BTN_N_LEFT,   1'b0);
        push_sample(2'b00, 2'b00, BTN_N_LEFT,   1'b1);
        push_sample(2'b11, 2'b11, BTN_N_MIDDLE, 1'b1);  // both pins flip: no count
        push_sample(2'b00, 2'b00, BTN_N_RIGHT,  1'b1);
        push_sample(2'b01, 2'b10, BTN_N_NONE,   1'b1);  // step on the report beat
        push_sample(2'b01, 2'b10, BTN_N_ALL,    1'b0);  // held phase
        push_sample(2'b01, 2'b10, BTN_N_NONE,   1'b1);
        push_sample(2'b00, 2'b11, BTN_N_ALL,    1'b0);
        push_sample(2'b10, 2'b01, BTN_N_ALL,    1'b0);
        push_sample(2'b11, 2'b00, BTN_N_ALL,    1'b1);
        wait_drained();

        // random phases, one count_scale setting each
        for (int i = 0; i < 7; i++) begin
            idle_on     = (i != 6);
            tx_idle_pct = (i % 3 == 2) ? 0 : $urandom_range(8, 25);
            rx_idle_pct = (i % 3 == 2) ? 0 : $urandom_range(8, 25);
            write_scale(scale_plan[i]);
            if (i == 1) begin
                // reports pile up behind a long receiver stall
                rx_hold_req = LONG_STALL;
                queue_motion(40, 90, 3);
                wait_drained();
            end
            queue_motion(40, 15, 4);
            queue_noise(10);
            wait_drained();
            queue_spin(24);
            wait_drained();
        end

        $display("Checked %0d reports from %0d samples over %0d count_scale settings",
                 reports_checked, samples_seen, settings_used);
        $display("Input held off for %0d cycles, %0d mismatches",
                 stall_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
